[rtl/core/npwr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwr_pkg
// Shared widths, codes and controller/datapath bundles for the
// nearest-point-within-radius search unit.
// ----------------------------------------------------------------------------
package npwr_pkg;

  // Table size and coordinate precision
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  // Fixed field widths of the channels
  localparam int IN_COORD_W = 16;
  localparam int SLOT_W     = 6;
  localparam int RADIUS_W   = 16;
  localparam int COUNT_W    = 7;
  localparam int IDX_W      = 6;
  localparam int DIST_W     = 34;

  // Derived internal widths
  localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int MAG_W   = COORD_BITS;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int SUM_W   = SQ_W + 2;
  localparam int RSQ_W   = 2 * RADIUS_W;
  localparam int BEST_W  = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

  // Item codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [IN_COORD_W-1:0] in_coord_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Controller to datapath
  typedef struct packed {
    logic  accept;   // input beat taken this cycle
    logic  issue;    // read one table entry into the pipe
    addr_t rd_addr;
    logic  finish;   // load the result register
  } npwr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } npwr_status_t;

endpackage

[rtl/core/npwr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwr_if
// Valid/ready channels of the search unit: request, result and count write.
// ----------------------------------------------------------------------------
interface npwr_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [npwr_pkg::SLOT_W-1:0]       slot;
  npwr_pkg::in_coord_t               coord_x;
  npwr_pkg::in_coord_t               coord_y;
  npwr_pkg::in_coord_t               coord_z;
  logic [npwr_pkg::RADIUS_W-1:0]     radius;

  modport source (output valid, cmd, slot, coord_x, coord_y, coord_z, radius,
                  input ready);
  modport sink   (input valid, cmd, slot, coord_x, coord_y, coord_z, radius,
                  output ready);
endinterface

interface npwr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [npwr_pkg::IDX_W-1:0]    best_index;
  logic [npwr_pkg::DIST_W-1:0]   best_dist_sq;

  modport source (output valid, found, best_index, best_dist_sq, input ready);
  modport sink   (input valid, found, best_index, best_dist_sq, output ready);
endinterface

interface npwr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [npwr_pkg::COUNT_W-1:0]  point_count;

  modport source (output valid, point_count, input ready);
  modport sink   (input valid, point_count, output ready);
endinterface

[rtl/core/npwr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwr_ctrl
// Sequencer: takes one beat, walks the table addresses for a query, waits
// for the distance pipe to drain, then hands the result to the output.
// ----------------------------------------------------------------------------
module npwr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_cmd,
  output logic                          req_ready,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic                          cfg_valid,
  input  logic [npwr_pkg::COUNT_W-1:0]  cfg_point_count,
  output npwr_pkg::npwr_cmd_t           cmd,
  input  npwr_pkg::npwr_status_t        status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t                       state;
  logic [npwr_pkg::COUNT_W-1:0] point_count;
  logic [npwr_pkg::CNT_W-1:0]   scan_cnt;
  logic [npwr_pkg::CNT_W-1:0]   scan_len;
  logic [npwr_pkg::CNT_W-1:0]   scan_len_next;
  logic                         accept;
  logic                         finish;

  // Entries to scan, clipped to the table size
  always_comb begin
    if (int'(point_count) > npwr_pkg::MAX_POINTS) begin
      scan_len_next = npwr_pkg::CNT_W'(npwr_pkg::MAX_POINTS);
    end else begin
      scan_len_next = npwr_pkg::CNT_W'(point_count);
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign finish    = (state == ST_DRAIN) && !status.pipe_busy
                     && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd.accept  = accept;
    cmd.issue   = (state == ST_SCAN);
    cmd.rd_addr = scan_cnt[npwr_pkg::ADDR_W-1:0];
    cmd.finish  = finish;
  end

  // State, count register and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      scan_cnt    <= '0;
      scan_len    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        point_count <= cfg_point_count;
      end

      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            scan_cnt <= '0;
            scan_len <= scan_len_next;
            if (req_cmd == npwr_pkg::CMD_QUERY && scan_len_next != '0) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt + 1'b1 == scan_len) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/npwr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwr_datapath
// Point table, four-stage squared-distance pipe, running best and the
// result register.
// ----------------------------------------------------------------------------
module npwr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  npwr_pkg::npwr_cmd_t            cmd,
  output npwr_pkg::npwr_status_t         status,
  input  logic                           req_cmd,
  input  logic [npwr_pkg::SLOT_W-1:0]    req_slot,
  input  npwr_pkg::in_coord_t            req_x,
  input  npwr_pkg::in_coord_t            req_y,
  input  npwr_pkg::in_coord_t            req_z,
  input  logic [npwr_pkg::RADIUS_W-1:0]  req_radius,
  output logic                           rsp_found,
  output logic [npwr_pkg::IDX_W-1:0]     rsp_best_index,
  output logic [npwr_pkg::DIST_W-1:0]    rsp_best_dist_sq
);

  localparam int CB = npwr_pkg::COORD_BITS;

  npwr_pkg::point_t              point_mem [npwr_pkg::MAX_POINTS];
  npwr_pkg::point_t              in_point;
  npwr_pkg::point_t              qry;
  logic                          is_load;

  npwr_pkg::point_t              s1_pt;
  npwr_pkg::addr_t               s1_idx;
  logic                          s1_valid;
  logic [npwr_pkg::MAG_W-1:0]    s2_mx, s2_my, s2_mz;
  npwr_pkg::addr_t               s2_idx;
  logic                          s2_valid;
  logic [npwr_pkg::SQ_W-1:0]     s3_sx, s3_sy, s3_sz;
  npwr_pkg::addr_t               s3_idx;
  logic                          s3_valid;
  logic [npwr_pkg::SUM_W-1:0]    s4_sum;
  npwr_pkg::addr_t               s4_idx;
  logic                          s4_valid;

  logic [npwr_pkg::BEST_W-1:0]   best_dist;
  npwr_pkg::addr_t               best_idx;
  logic                          hit;
  logic                          closer;

  // Absolute difference of two coordinates
  function automatic logic [npwr_pkg::MAG_W-1:0] abs_diff(
    input npwr_pkg::coord_t a,
    input npwr_pkg::coord_t b
  );
    logic signed [npwr_pkg::DIFF_W-1:0] d;
    d = {a[CB-1], a} - {b[CB-1], b};
    if (d[npwr_pkg::DIFF_W-1]) begin
      d = -d;
    end
    return d[npwr_pkg::MAG_W-1:0];
  endfunction

  // Input coordinates brought to table precision, bits taken as given
  always_comb begin
    in_point.x = npwr_pkg::coord_t'($unsigned(req_x));
    in_point.y = npwr_pkg::coord_t'($unsigned(req_y));
    in_point.z = npwr_pkg::coord_t'($unsigned(req_z));
  end

  // Table write on a load beat, registered read during a scan
  always_ff @(posedge clk) begin
    if (cmd.accept && req_cmd == npwr_pkg::CMD_LOAD
        && int'(req_slot) < npwr_pkg::MAX_POINTS) begin
      point_mem[npwr_pkg::ADDR_W'(req_slot)] <= in_point;
    end
    if (cmd.issue) begin
      s1_pt <= point_mem[cmd.rd_addr];
    end
  end

  // Pipe valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Distance pipe: difference magnitude, square, sum
  always_ff @(posedge clk) begin
    s1_idx <= cmd.rd_addr;
    s2_mx  <= abs_diff(s1_pt.x, qry.x);
    s2_my  <= abs_diff(s1_pt.y, qry.y);
    s2_mz  <= abs_diff(s1_pt.z, qry.z);
    s2_idx <= s1_idx;
    s3_sx  <= npwr_pkg::SQ_W'(s2_mx * s2_mx);
    s3_sy  <= npwr_pkg::SQ_W'(s2_my * s2_my);
    s3_sz  <= npwr_pkg::SQ_W'(s2_mz * s2_mz);
    s3_idx <= s2_idx;
    s4_sum <= npwr_pkg::SUM_W'(s3_sx) + npwr_pkg::SUM_W'(s3_sy)
              + npwr_pkg::SUM_W'(s3_sz);
    s4_idx <= s3_idx;
  end

  assign closer           = s4_valid && (npwr_pkg::BEST_W'(s4_sum) < best_dist);
  assign status.pipe_busy = s1_valid || s2_valid || s3_valid || s4_valid;

  // Query setup and running best; strict compare keeps the earlier index
  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist <= '0;
      best_idx  <= '0;
      hit       <= 1'b0;
      is_load   <= 1'b0;
    end else if (cmd.accept) begin
      is_load <= (req_cmd == npwr_pkg::CMD_LOAD);
      if (req_cmd == npwr_pkg::CMD_QUERY) begin
        qry       <= in_point;
        best_dist <= npwr_pkg::BEST_W'(req_radius * req_radius);
        best_idx  <= '0;
        hit       <= 1'b0;
      end
    end else if (closer) begin
      best_dist <= npwr_pkg::BEST_W'(s4_sum);
      best_idx  <= s4_idx;
      hit       <= 1'b1;
    end
  end

  // Result register; a load answers with all zeros
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (is_load) begin
        rsp_found        <= 1'b0;
        rsp_best_index   <= '0;
        rsp_best_dist_sq <= '0;
      end else begin
        rsp_found        <= hit;
        rsp_best_index   <= npwr_pkg::IDX_W'(best_idx);
        rsp_best_dist_sq <= npwr_pkg::DIST_W'(best_dist);
      end
    end
  end

endmodule

[rtl/core/nearest_point_within_radius_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_within_radius_unit
// Linear nearest-point search over a 64-entry table of 3D points.
// ----------------------------------------------------------------------------
// A load beat (cmd 0) writes one point into the table and returns an all-zero
// result. A query beat (cmd 1) scans entries 0 to point_count-1 (clipped to
// 64), one table read per cycle through the single read port of the point
// table, and feeds a four-stage squared-distance pipe. It returns the nearest
// entry strictly closer than the running best, which starts at radius squared;
// a tie keeps the lower index. A query with a count of zero answers without a
// scan, as a load does. One item is worked on at a time, and a new request
// is taken while the previous result still waits on rsp.
// Table entries must be loaded before a query reads them. The count register
// must be written through cfg only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module nearest_point_within_radius_unit (
  input  logic         clk,
  input  logic         rst,
  npwr_req_if.sink     req,
  npwr_rsp_if.source   rsp,
  npwr_cfg_if.sink     cfg
);

  npwr_pkg::npwr_cmd_t    cmd;
  npwr_pkg::npwr_status_t status;

  assign cfg.ready = 1'b1;

  // Sequencer
  npwr_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req.valid),
    .req_cmd         (req.cmd),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .cfg_valid       (cfg.valid),
    .cfg_point_count (cfg.point_count),
    .cmd             (cmd),
    .status          (status)
  );

  // Table and distance pipe
  npwr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .req_cmd          (req.cmd),
    .req_slot         (req.slot),
    .req_x            (req.coord_x),
    .req_y            (req.coord_y),
    .req_z            (req.coord_z),
    .req_radius       (req.radius),
    .rsp_found        (rsp.found),
    .rsp_best_index   (rsp.best_index),
    .rsp_best_dist_sq (rsp.best_dist_sq)
  );

endmodule

[rtl/core/npwr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npwr_checker
// Port-level checks on the search unit, bound to the top level.
// ----------------------------------------------------------------------------
module npwr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_found,
  input logic [npwr_pkg::IDX_W-1:0]    rsp_best_index,
  input logic [npwr_pkg::DIST_W-1:0]   rsp_best_dist_sq
);

  // One item at a time: a taken beat makes the block busy
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in progress");

  // A result only appears after the block was busy working on it
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result raised without an item in progress");

  // No hit means no index
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> rsp_best_index == '0)
    else $error("index non-zero on a miss");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
      && $stable(rsp_best_index) && $stable(rsp_best_dist_sq))
    else $error("result changed while stalled");

endmodule

bind nearest_point_within_radius_unit npwr_checker u_npwr_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_found        (rsp.found),
  .rsp_best_index   (rsp.best_index),
  .rsp_best_dist_sq (rsp.best_dist_sq)
);

[verif/nearest_point_within_radius_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_within_radius_unit_test
// Self-checking bench for the nearest-point search unit: loads points into
// the table, runs queries under several scan counts and compares every result
// beat against a local model of the linear search, with random idling on the
// request and result channels.
// ----------------------------------------------------------------------------
module nearest_point_within_radius_unit_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  // Search model and store of expected result beats
  class search_scoreboard;
    typedef struct {
      logic                           found;
      logic [npwr_pkg::IDX_W-1:0]     idx;
      logic [npwr_pkg::DIST_W-1:0]    dsq;
    } hit_t;

    npwr_pkg::point_t                 pts[npwr_pkg::MAX_POINTS];
    logic [npwr_pkg::COUNT_W-1:0]     scan_count = '0;
    hit_t                             expected_hits[$];
    int                               mismatches = 0;
    int                               loads = 0;
    int                               queries = 0;
    int                               hits = 0;

    function void set_count(logic [npwr_pkg::COUNT_W-1:0] v);
      scan_count = v;
    endfunction

    function longint sq_gap(npwr_pkg::coord_t a, npwr_pkg::coord_t b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    // Work out the result of one accepted request beat
    function void note_beat(logic cmd, logic [npwr_pkg::SLOT_W-1:0] slot,
                            npwr_pkg::in_coord_t x, npwr_pkg::in_coord_t y,
                            npwr_pkg::in_coord_t z,
                            logic [npwr_pkg::RADIUS_W-1:0] radius);
      hit_t   e;
      int     n;
      longint best;
      longint d;
      e = '{found: 1'b0, idx: '0, dsq: '0};
      if (cmd == npwr_pkg::CMD_LOAD) begin
        pts[slot] = '{x: x, y: y, z: z};
        loads++;
      end else begin
        n = (scan_count > npwr_pkg::MAX_POINTS) ? npwr_pkg::MAX_POINTS
                                                 : int'(scan_count);
        best = longint'(radius) * longint'(radius);
        for (int i = 0; i < n; i++) begin
          d = sq_gap(pts[i].x, x) + sq_gap(pts[i].y, y) + sq_gap(pts[i].z, z);
          // strictly closer only: ties keep the earlier entry
          if (d < best) begin
            best = d;
            e.idx = npwr_pkg::IDX_W'(i);
            e.found = 1'b1;
          end
        end
        e.dsq = npwr_pkg::DIST_W'(best);
        queries++;
        if (e.found) hits++;
      end
      expected_hits.insert(expected_hits.size(), e);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(logic found, logic [npwr_pkg::IDX_W-1:0] idx,
                               logic [npwr_pkg::DIST_W-1:0] dsq);
      hit_t e;
      if (expected_hits.size() == 0) begin
        flag($sformatf("result beat with none pending: found=%0b idx=%0d dist=%0d",
                       found, idx, dsq));
        return;
      end
      e = expected_hits.pop_front();
      if (found !== e.found || idx !== e.idx || dsq !== e.dsq)
        flag($sformatf("exp found=%0b idx=%0d dist=%0d, got found=%0b idx=%0d dist=%0d",
                       e.found, e.idx, e.dsq, found, idx, dsq));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic allow_idle;
  int   cycle_count = 0;
  int   settings = 0;

  search_scoreboard sb;

  npwr_req_if req_ch ();
  npwr_rsp_if rsp_ch ();
  npwr_cfg_if cfg_ch ();

  nearest_point_within_radius_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("nearest_point_within_radius_unit_test: errors");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.found, rsp_ch.best_index, rsp_ch.best_dist_sq);
  end

  // Result-side back-pressure in random bursts
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (allow_idle && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic npwr_pkg::in_coord_t clamp_coord(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return npwr_pkg::in_coord_t'(v);
  endfunction

  // Mostly a tight cluster round the origin, with full-range and edge values
  function automatic npwr_pkg::in_coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2: return npwr_pkg::in_coord_t'($urandom_range(0, 65535));
      default: return clamp_coord(int'($urandom_range(0, 800)) - 400);
    endcase
  endfunction

  function automatic npwr_pkg::in_coord_t nudge(npwr_pkg::coord_t c);
    return clamp_coord(int'(c) + int'($urandom_range(0, 60)) - 30);
  endfunction

  function automatic logic [npwr_pkg::RADIUS_W-1:0] rand_radius();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return npwr_pkg::RADIUS_W'($urandom_range(0, 65535));
      default: return npwr_pkg::RADIUS_W'($urandom_range(0, 600));
    endcase
  endfunction

  // One request beat, with an optional idle burst ahead of it
  task automatic send_item(logic cmd, logic [npwr_pkg::SLOT_W-1:0] slot,
                           npwr_pkg::in_coord_t x, npwr_pkg::in_coord_t y,
                           npwr_pkg::in_coord_t z,
                           logic [npwr_pkg::RADIUS_W-1:0] radius);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= cmd;
    req_ch.slot    <= slot;
    req_ch.coord_x <= x;
    req_ch.coord_y <= y;
    req_ch.coord_z <= z;
    req_ch.radius  <= radius;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_beat(cmd, slot, x, y, z, radius);
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_count(logic [npwr_pkg::COUNT_W-1:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.point_count <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_count(v);
    settings++;
  endtask

  task automatic random_item();
    npwr_pkg::point_t p;
    if ($urandom_range(0, 99) < 35) begin
      send_item(npwr_pkg::CMD_LOAD,
                npwr_pkg::SLOT_W'($urandom_range(0, npwr_pkg::MAX_POINTS - 1)),
                rand_coord(), rand_coord(), rand_coord(), rand_radius());
    end else if ($urandom_range(0, 1) == 0) begin
      // query close to a stored point, so hits and near-ties are common
      p = sb.pts[$urandom_range(0, npwr_pkg::MAX_POINTS - 1)];
      send_item(npwr_pkg::CMD_QUERY, npwr_pkg::SLOT_W'($urandom_range(0, 63)),
                nudge(p.x), nudge(p.y), nudge(p.z), rand_radius());
    end else begin
      send_item(npwr_pkg::CMD_QUERY, npwr_pkg::SLOT_W'($urandom_range(0, 63)),
                rand_coord(), rand_coord(), rand_coord(), rand_radius());
    end
  endtask

  initial begin
    logic [npwr_pkg::COUNT_W-1:0] phase_counts[8];
    sb = new();
    allow_idle         = 1'b1;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = npwr_pkg::CMD_LOAD;
    req_ch.slot        = '0;
    req_ch.coord_x     = '0;
    req_ch.coord_y     = '0;
    req_ch.coord_z     = '0;
    req_ch.radius      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.point_count = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Count still at reset: nothing scanned, result carries radius squared
    send_item(npwr_pkg::CMD_QUERY, 6'd0, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'hFFFF);

    // Corner points, a duplicate pair for the tie rule, and the top slot
    send_item(npwr_pkg::CMD_LOAD, 6'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000);
    send_item(npwr_pkg::CMD_LOAD, 6'd1, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
    send_item(npwr_pkg::CMD_LOAD, 6'd2, 16'sh0000, 16'sh0000, 16'sh0000, 16'h5555);
    send_item(npwr_pkg::CMD_LOAD, 6'd3, 16'sh0000, 16'sh0000, 16'sh0000, 16'hAAAA);
    send_item(npwr_pkg::CMD_LOAD, 6'd63, 16'sd100, -16'sd100, 16'sd5, 16'h0001);
    settle();
    write_count(7'd4);

    send_item(npwr_pkg::CMD_QUERY, 6'd63, 16'sh0000, 16'sh0000, 16'sh0000, 16'hFFFF);
    send_item(npwr_pkg::CMD_QUERY, 6'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000);
    send_item(npwr_pkg::CMD_QUERY, 6'd21, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
    send_item(npwr_pkg::CMD_QUERY, 6'd42, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0001);
    send_item(npwr_pkg::CMD_QUERY, 6'd0, 16'sd1, 16'sd1, 16'sd0, 16'h0002);
    send_item(npwr_pkg::CMD_QUERY, 6'd0, 16'sd1, 16'sd1, 16'sd1, 16'h0001);
    send_item(npwr_pkg::CMD_QUERY, 6'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF);
    send_item(npwr_pkg::CMD_QUERY, 6'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);

    // Fill the rest of the table so any count is safe from here on
    for (int s = 4; s < npwr_pkg::MAX_POINTS - 1; s++)
      send_item(npwr_pkg::CMD_LOAD, npwr_pkg::SLOT_W'(s), rand_coord(), rand_coord(),
                rand_coord(), rand_radius());
    settle();

    phase_counts = '{7'd64, 7'd127, 7'd1, 7'd65,
                     npwr_pkg::COUNT_W'($urandom_range(2, 63)), 7'd0,
                     npwr_pkg::COUNT_W'($urandom_range(0, 127)), 7'd64};
    foreach (phase_counts[ph]) begin
      write_count(phase_counts[ph]);
      // last phase runs flat out on both sides
      if (ph == 7) allow_idle = 1'b0;
      repeat (95) random_item();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_hits.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.expected_hits.size()));

    $display("covered %0d loads and %0d queries, %0d of them inside the radius",
             sb.loads, sb.queries, sb.hits);
    $display("over %0d scan-count settings; %0d mismatches", settings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("nearest_point_within_radius_unit_test: clean");
    end else begin
      $display("nearest_point_within_radius_unit_test: errors");
    end
    $finish;
  end

endmodule
